// ----- rtl/core/hsa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsa_pkg
// shared constants for the hsv saturation adjust core
// ----------------------------------------------------------------------------
package hsa_pkg;

    localparam int COMPONENT_BITS_DEF = 8;
    localparam int FRACTION_BITS_DEF  = 16;

    // saturation scale register, unsigned q4.12
    localparam int SCALE_BITS      = 16;
    localparam int SCALE_FRAC_BITS = 12;
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd4096;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

endpackage
`default_nettype wire

// ----- rtl/core/hsv_saturation_adjust_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_saturation_adjust_core
// scales the hsv saturation of a stream of packed rgb pixels
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one pixel per clock, in order. Each
// pixel keeps its hue and value (largest component) while its saturation is
// multiplied by the q4.12 factor in the config register (4096 = unchanged)
// and clamped to one; each component is rebuilt and rounded half up. Grey
// pixels pass unchanged. The front stage finds max/min/delta and hands the
// request through a four-entry queue to the back pipeline, which holds a
// FRACTION_BITS+1 stage saturation divider, five multiply/clamp stages and a
// COMPONENT_BITS stage divider per component. The sustained rate is one
// pixel per cycle, with the whole back pipeline held only while the output
// register is full and not taken. Write the scale only while no pixel is in
// flight.
// ----------------------------------------------------------------------------
module hsv_saturation_adjust_core #(
    parameter int COMPONENT_BITS = hsa_pkg::COMPONENT_BITS_DEF,
    parameter int FRACTION_BITS  = hsa_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // pixel input
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,  // color_in
    // pixel output
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [((3*COMPONENT_BITS+7)/8)*8-1:0] m_tdata,       // color_out
    // saturation scale write
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [hsa_pkg::SCALE_BITS-1:0] cfg_data
);
    import hsa_pkg::*;

    localparam int CB     = COMPONENT_BITS;
    localparam int PIX_W  = 3 * CB;
    localparam int DATA_W = ((PIX_W + 7) / 8) * 8;

    // config register, always ready
    logic [SCALE_BITS-1:0] scale_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
        end else if (cfg_valid) begin
            scale_reg <= cfg_data;
        end
    end

    // front: accept and classify
    logic          q_full, q_push, q_pop, q_not_empty;
    logic [5*CB-1:0] q_in, q_out;

    hsa_front #(
        .COMPONENT_BITS(CB)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .in_pix  (s_tdata[PIX_W-1:0]),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    hsa_queue #(
        .WIDTH(5 * CB),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_in),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .pop_data (q_out)
    );

    // back pipeline advances whenever the output register can take a result
    logic             adv;
    logic             back_valid;
    logic [PIX_W-1:0] back_pix;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_pix_reg;

    assign adv   = !out_valid_reg || m_tready;
    assign q_pop = adv && q_not_empty;

    hsa_back #(
        .COMPONENT_BITS(CB),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (q_pop),
        .in_data  (q_out),
        .scale    (scale_reg),
        .out_valid(back_valid),
        .out_pix  (back_pix)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= back_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_pix_reg <= back_pix;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'(out_pix_reg);

endmodule
`default_nettype wire

// ----- rtl/core/hsa_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsa_div
// pipelined restoring divider, one quotient bit per stage, with sideband
// ----------------------------------------------------------------------------
module hsa_div #(
    parameter int NUM_W  = 24,
    parameter int DEN_W  = 8,
    parameter int QUO_W  = 17,
    parameter int SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  in_num,
    input  wire logic [DEN_W-1:0]  in_den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [QUO_W-1:0]       out_quo,
    output logic [SIDE_W-1:0]      out_side
);
    localparam int REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [REM_W-1:0]  src_rem  [0:QUO_W-1];
    logic [QUO_W-1:0]  src_quo  [0:QUO_W-1];
    logic [DEN_W-1:0]  src_den  [0:QUO_W-1];
    logic [SIDE_W-1:0] src_side [0:QUO_W-1];
    logic              src_vld  [0:QUO_W-1];

    logic [REM_W-1:0]  rem_reg  [0:QUO_W-1];
    logic [QUO_W-1:0]  quo_reg  [0:QUO_W-1];
    logic [DEN_W-1:0]  den_reg  [0:QUO_W-1];
    logic [SIDE_W-1:0] side_reg [0:QUO_W-1];
    logic              vld_reg  [0:QUO_W-1];

    assign src_rem[0]  = REM_W'(in_num);
    assign src_quo[0]  = '0;
    assign src_den[0]  = in_den;
    assign src_side[0] = in_side;
    assign src_vld[0]  = in_valid;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (k > 0) begin : g_link
            assign src_rem[k]  = rem_reg[k-1];
            assign src_quo[k]  = quo_reg[k-1];
            assign src_den[k]  = den_reg[k-1];
            assign src_side[k] = side_reg[k-1];
            assign src_vld[k]  = vld_reg[k-1];
        end

        // this stage decides quotient bit QUO_W-1-k
        assign trial = REM_W'(src_den[k]) << (QUO_W - 1 - k);

        always_comb begin
            rem_next = src_rem[k];
            quo_next = src_quo[k];
            if (src_rem[k] >= trial) begin
                rem_next = src_rem[k] - trial;
                quo_next[QUO_W-1-k] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= src_vld[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                den_reg[k]  <= src_den[k];
                side_reg[k] <= src_side[k];
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule
`default_nettype wire

// ----- rtl/core/hsa_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsa_front
// accepts pixels and finds max, min and delta of the components
// ----------------------------------------------------------------------------
module hsa_front #(
    parameter int COMPONENT_BITS = 8
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [3*COMPONENT_BITS-1:0] in_pix,
    input  wire logic                        q_full,
    output logic                             q_push,
    output logic [5*COMPONENT_BITS-1:0]      q_data
);
    import hsa_pkg::*;

    localparam int CB = COMPONENT_BITS;

    logic [CB-1:0] r, g, b, cmax, cmin;
    logic          accept;

    logic            valid_reg;
    logic [3*CB-1:0] pix_reg;
    logic [CB-1:0]   cmax_reg;
    logic [CB-1:0]   delta_reg;

    assign r = in_pix[3*CB-1:2*CB];
    assign g = in_pix[2*CB-1:CB];
    assign b = in_pix[CB-1:0];

    always_comb begin
        cmax = r;
        cmin = r;
        if (g > cmax) cmax = g;
        if (b > cmax) cmax = b;
        if (g < cmin) cmin = g;
        if (b < cmin) cmin = b;
    end

    assign q_push   = valid_reg && !q_full;
    assign in_ready = !valid_reg || !q_full;
    assign accept   = in_valid && in_ready;
    assign q_data   = {pix_reg, cmax_reg, delta_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (q_push) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg   <= in_pix;
            cmax_reg  <= cmax;
            delta_reg <= cmax - cmin;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/hsa_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsa_queue
// short fifo between the classify front and the arithmetic back
// ----------------------------------------------------------------------------
module hsa_queue #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      pop_data
);
    import hsa_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0]  store [0:DEPTH-1];
    logic [ADDR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ADDR_W:0]   count_reg;

    assign full      = (count_reg == (ADDR_W + 1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = store[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push) else $error("request pushed into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty) else $error("request popped from empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (ADDR_W + 1)'(DEPTH)) else $error("queue count overflow");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/hsa_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsa_back
// saturation scaling and rgb rebuild pipeline
// ----------------------------------------------------------------------------
module hsa_back #(
    parameter int COMPONENT_BITS = 8,
    parameter int FRACTION_BITS  = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [5*COMPONENT_BITS-1:0]   in_data,
    input  wire logic [hsa_pkg::SCALE_BITS-1:0] scale,
    output logic                               out_valid,
    output logic [3*COMPONENT_BITS-1:0]        out_pix
);
    import hsa_pkg::*;

    localparam int CB     = COMPONENT_BITS;
    localparam int FB     = FRACTION_BITS;
    localparam int S_W    = FB + 1;
    localparam int PROD_W = S_W + SCALE_BITS;
    localparam int P_W    = 2 * CB + 1;
    localparam int CS_W   = CB + S_W;
    localparam int N_W    = 2 * CB + FB + 1;
    localparam int SIDE_W = 5 * CB;

    // stage 0: split queue entry, start saturation divide
    logic [3*CB-1:0] pix0;
    logic [CB-1:0]   cmax0, delta0;
    assign pix0   = in_data[5*CB-1:2*CB];
    assign cmax0  = in_data[2*CB-1:CB];
    assign delta0 = in_data[CB-1:0];

    logic              sd_valid;
    logic [S_W-1:0]    sd_quo;
    logic [SIDE_W-1:0] sd_side;

    hsa_div #(
        .NUM_W (CB + FB),
        .DEN_W (CB),
        .QUO_W (S_W),
        .SIDE_W(SIDE_W)
    ) u_sat_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (in_valid),
        .in_num   ({delta0, {FB{1'b0}}}),
        .in_den   (cmax0),
        .in_side  (in_data),
        .out_valid(sd_valid),
        .out_quo  (sd_quo),
        .out_side (sd_side)
    );

    logic [3*CB-1:0] pix1;
    logic [CB-1:0]   cmax1, delta1;
    assign pix1   = sd_side[5*CB-1:2*CB];
    assign cmax1  = sd_side[2*CB-1:CB];
    assign delta1 = sd_side[CB-1:0];

    // stage 1: s * scale, chroma term, per component distance from max
    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [PROD_W-1:0] prod1_reg;
    logic [P_W-1:0]    p1_reg, p2_reg, p3_reg, p4_reg;
    logic [3*CB-1:0]   pix1_reg, pix2_reg, pix3_reg, pix4_reg, pix5_reg;
    logic [CB-1:0]     cmax1_reg, cmax2_reg;
    logic [CB-1:0]     delta1_reg, delta2_reg, delta3_reg, delta4_reg, delta5_reg;
    logic [3*CB-1:0]   dist1_reg, dist2_reg, dist3_reg;
    logic [S_W-1:0]    s2_2_reg;
    logic [CS_W-1:0]   cs3_reg;
    logic [N_W-1:0]    num4_reg [0:2];
    logic [N_W-1:0]    n5_reg   [0:2];

    logic [PROD_W-SCALE_FRAC_BITS-1:0] s2_raw;
    assign s2_raw = prod1_reg[PROD_W-1:SCALE_FRAC_BITS];

    logic [N_W:0] pshift4;
    assign pshift4 = (N_W + 1)'({p4_reg, {FB{1'b0}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= sd_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1
            prod1_reg  <= PROD_W'(sd_quo) * PROD_W'(scale);
            p1_reg     <= P_W'({cmax1, 1'b1}) * P_W'(delta1);
            pix1_reg   <= pix1;
            cmax1_reg  <= cmax1;
            delta1_reg <= delta1;
            dist1_reg  <= {cmax1 - pix1[3*CB-1:2*CB],
                           cmax1 - pix1[2*CB-1:CB],
                           cmax1 - pix1[CB-1:0]};
            // stage 2: clamp scaled saturation to one
            s2_2_reg   <= (s2_raw > (PROD_W - SCALE_FRAC_BITS)'(1 << FB)) ?
                          S_W'(1 << FB) : S_W'(s2_raw);
            p2_reg     <= p1_reg;
            pix2_reg   <= pix1_reg;
            cmax2_reg  <= cmax1_reg;
            delta2_reg <= delta1_reg;
            dist2_reg  <= dist1_reg;
            // stage 3: cmax * s2
            cs3_reg    <= CS_W'(cmax2_reg) * CS_W'(s2_2_reg);
            p3_reg     <= p2_reg;
            pix3_reg   <= pix2_reg;
            delta3_reg <= delta2_reg;
            dist3_reg  <= dist2_reg;
            // stage 4: times distance of each component
            num4_reg[0] <= N_W'(cs3_reg) * N_W'(dist3_reg[3*CB-1:2*CB]);
            num4_reg[1] <= N_W'(cs3_reg) * N_W'(dist3_reg[2*CB-1:CB]);
            num4_reg[2] <= N_W'(cs3_reg) * N_W'(dist3_reg[CB-1:0]);
            p4_reg     <= p3_reg;
            pix4_reg   <= pix3_reg;
            delta4_reg <= delta3_reg;
            // stage 5: rounding numerator (2*cmax+1)*delta*2^F - 2*num
            for (int i = 0; i < 3; i++) begin
                n5_reg[i] <= N_W'(pshift4 - {num4_reg[i], 1'b0});
            end
            pix5_reg   <= pix4_reg;
            delta5_reg <= delta4_reg;
        end
    end

    // component dividers by delta * 2^(F+1)
    logic [CB-1:0]   quo [0:2];
    logic [2:0]      cd_valid;
    logic [3*CB:0]   cd_side [0:2];

    for (genvar i = 0; i < 3; i++) begin : g_comp
        hsa_div #(
            .NUM_W (N_W),
            .DEN_W (CB + FB + 1),
            .QUO_W (CB),
            .SIDE_W(3 * CB + 1)
        ) u_comp_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (v5_reg),
            .in_num   (n5_reg[i]),
            .in_den   ({delta5_reg, {(FB + 1){1'b0}}}),
            .in_side  ({pix5_reg, (delta5_reg == '0)}),
            .out_valid(cd_valid[i]),
            .out_quo  (quo[i]),
            .out_side (cd_side[i])
        );
    end

    // grey pixels pass unchanged
    assign out_valid = cd_valid[0] && cd_valid[1] && cd_valid[2];
    assign out_pix   = cd_side[0][0] ? cd_side[0][3*CB:1] : {quo[0], quo[1], quo[2]};

endmodule
`default_nettype wire
